// ----- rtl/core/md4_pkg.sv -----
// shared types and constants for the md4 digest core
`default_nettype none
package md4_pkg;
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        half_index;
    logic        last_half;
  } out_req_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] K1 = 32'h5a827999;
  localparam logic [31:0] K2 = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  function automatic logic [3:0] word_sel(input logic [5:0] r);
    logic [3:0] i;
    begin
      i = r[3:0];
      case (r[5:4])
        2'd0: word_sel = i;
        2'd1: word_sel = {i[1:0], i[3:2]};
        default: word_sel = {i[0], i[1], i[2], i[3]};
      endcase
    end
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    begin
      case ({r[5:4], r[1:0]})
        4'b0000: rot_amt = 5'd3;
        4'b0001: rot_amt = 5'd7;
        4'b0010: rot_amt = 5'd11;
        4'b0011: rot_amt = 5'd19;
        4'b0100: rot_amt = 5'd3;
        4'b0101: rot_amt = 5'd5;
        4'b0110: rot_amt = 5'd9;
        4'b0111: rot_amt = 5'd13;
        4'b1000: rot_amt = 5'd3;
        4'b1001: rot_amt = 5'd9;
        4'b1010: rot_amt = 5'd11;
        default: rot_amt = 5'd15;
      endcase
    end
  endfunction
endpackage
`default_nettype wire

// ----- rtl/core/md4_queue.sv -----
// two-entry request queue between the front and the back of the md4 core
`default_nettype none
module md4_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire md4_pkg::in_req_t wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output md4_pkg::in_req_t      rd_data,
  output logic                  not_empty
);
  md4_pkg::in_req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assign rd_data   = mem_r[rp_r];
  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !not_empty |-> !rd_en) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

// ----- rtl/core/md4_back.sv -----
// back end: byte packing, padding, 48-round compression and digest output
`default_nettype none
module md4_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire md4_pkg::in_req_t req,
  input  wire logic             req_valid,
  output logic                  req_take,
  output md4_pkg::out_req_t     out_data,
  output logic                  out_valid,
  input  wire logic             out_stall
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PACK = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_PAD = 3'd3;
  localparam logic [2:0] ST_LEN = 3'd4;
  localparam logic [2:0] ST_OUT0 = 3'd5;
  localparam logic [2:0] ST_OUT1 = 3'd6;

  logic [2:0]  state_r;
  logic [31:0] blk_r [16];
  logic [31:0] ch_r [4];
  logic [31:0] v_r [4];
  logic [5:0]  pos_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic [31:0] data_r;
  logic [2:0]  left_r;
  logic        end_r;
  logic        fin_r;     // compression is the last (length) block
  logic        padded_r;  // 0x80 already placed

  // one round
  logic [1:0]  slot;
  logic [31:0] rb, rc, rd, f, k, sum, rot;
  logic [4:0]  s;
  always_comb begin
    slot = 2'd0 - rnd_r[1:0];
    rb = v_r[slot + 2'd1];
    rc = v_r[slot + 2'd2];
    rd = v_r[slot + 2'd3];
    case (rnd_r[5:4])
      2'd0: begin
        f = (rb & rc) | (~rb & rd);
        k = 32'd0;
      end
      2'd1: begin
        f = (rb & rc) | (rb & rd) | (rc & rd);
        k = md4_pkg::K1;
      end
      default: begin
        f = rb ^ rc ^ rd;
        k = md4_pkg::K2;
      end
    endcase
    sum = v_r[slot] + f + blk_r[md4_pkg::word_sel(rnd_r)] + k;
    s = md4_pkg::rot_amt(rnd_r);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  logic [2:0] cnt_in;
  assign cnt_in = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
  assign req_take = (state_r == ST_IDLE) && req_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= 6'd0;
      len_r   <= 64'd0;
      ch_r[0] <= md4_pkg::INIT_A;
      ch_r[1] <= md4_pkg::INIT_B;
      ch_r[2] <= md4_pkg::INIT_C;
      ch_r[3] <= md4_pkg::INIT_D;
      rnd_r   <= 6'd0;
      fin_r   <= 1'b0;
      padded_r <= 1'b0;
      left_r  <= 3'd0;
      end_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (req_valid) begin
            data_r <= req.data_word;
            left_r <= cnt_in;
            end_r  <= req.end_of_message;
            len_r  <= len_r + {58'd0, cnt_in, 3'd0};
            state_r <= ST_PACK;
          end
        end
        ST_PACK: begin
          if (left_r != 3'd0) begin
            blk_r[pos_r[5:2]][pos_r[1:0]*8 +: 8] <= data_r[7:0];
            data_r <= data_r >> 8;
            left_r <= left_r - 3'd1;
            pos_r  <= pos_r + 6'd1;
            if (pos_r == 6'd63) begin
              for (int i = 0; i < 4; i++) v_r[i] <= ch_r[i];
              rnd_r <= 6'd0;
              fin_r <= 1'b0;
              state_r <= ST_ROUND;
            end
          end else if (end_r) begin
            padded_r <= 1'b0;
            state_r <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_PAD: begin
          // place 0x80 then zero one byte a cycle up to the length field, or to the block end when the pad spills
          blk_r[pos_r[5:2]][pos_r[1:0]*8 +: 8] <= padded_r ? 8'd0 : md4_pkg::PAD_BYTE;
          padded_r <= 1'b1;
          pos_r <= pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            for (int i = 0; i < 4; i++) v_r[i] <= ch_r[i];
            rnd_r <= 6'd0;
            fin_r <= 1'b0;
            state_r <= ST_ROUND;
          end else if (pos_r == 6'd55) begin
            state_r <= ST_LEN;
          end
        end
        ST_LEN: begin
          blk_r[14] <= len_r[31:0];
          blk_r[15] <= len_r[63:32];
          for (int i = 0; i < 4; i++) v_r[i] <= ch_r[i];
          rnd_r <= 6'd0;
          fin_r <= 1'b1;
          state_r <= ST_ROUND;
        end
        ST_ROUND: begin
          v_r[slot] <= rot;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd47) begin
            ch_r[0] <= ch_r[0] + (slot == 2'd0 ? rot : v_r[0]);
            ch_r[1] <= ch_r[1] + (slot == 2'd1 ? rot : v_r[1]);
            ch_r[2] <= ch_r[2] + (slot == 2'd2 ? rot : v_r[2]);
            ch_r[3] <= ch_r[3] + (slot == 2'd3 ? rot : v_r[3]);
            if (fin_r) begin
              state_r <= ST_OUT0;
            end else if (padded_r && end_r && left_r == 3'd0) begin
              // pad spilled: second block of zeros plus length
              for (int i = 0; i < 14; i++) blk_r[i] <= 32'd0;
              state_r <= ST_LEN;
            end else begin
              state_r <= ST_PACK;
            end
          end
        end
        ST_OUT0: begin
          if (!out_stall) state_r <= ST_OUT1;
        end
        ST_OUT1: begin
          if (!out_stall) begin
            ch_r[0] <= md4_pkg::INIT_A;
            ch_r[1] <= md4_pkg::INIT_B;
            ch_r[2] <= md4_pkg::INIT_C;
            ch_r[3] <= md4_pkg::INIT_D;
            pos_r <= 6'd0;
            len_r <= 64'd0;
            padded_r <= 1'b0;
            end_r <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_valid = (state_r == ST_OUT0) || (state_r == ST_OUT1);
    out_data.half_index = (state_r == ST_OUT1);
    out_data.last_half  = (state_r == ST_OUT1);
    out_data.digest_half = (state_r == ST_OUT1) ? {ch_r[3], ch_r[2]} : {ch_r[1], ch_r[0]};
  end

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |=> state_r == ST_PACK) else $error("take without pack");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("result moved");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> rnd_r < 6'd48) else $error("round out of range");
endmodule
`default_nettype wire

// ----- rtl/core/md4_message_digest_core.sv -----
// top level of the md4 message digest core
// md4 (rfc 1320) hash engine. each request carries up to four message bytes
// (first byte in bits 7:0) and an end flag; a byte count above four counts
// as four. a two-entry queue takes requests while the back end works. the
// back end packs one byte per cycle, runs the 48 md4 rounds one per cycle
// on each full 64-byte block (one shared round unit). on the end flag
// padding is written one byte per cycle, then one or two final compressions
// run and the digest leaves as two 64-bit results (bytes 0-7, then 8-15 with
// last_half set); the core then restarts for a new message
`default_nettype none
module md4_message_digest_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire md4_pkg::in_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output md4_pkg::out_req_t     out_data
);
  md4_pkg::in_req_t q_data;
  logic q_full, q_ne, q_take;

  // front: queue accepts a request whenever there is room
  assign in_stall = q_full;

  md4_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_valid && !q_full),
    .wr_data   (in_data),
    .full      (q_full),
    .rd_en     (q_take),
    .rd_data   (q_data),
    .not_empty (q_ne)
  );

  // back: hashing engine and result port
  md4_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (q_data),
    .req_valid (q_ne),
    .req_take  (q_take),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  a_last_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_half) |-> out_data.half_index)
    else $error("last flag on first half");
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_ne) else $error("take from empty queue");
  a_half_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.half_index) |=>
      (out_valid && out_data.half_index)) else $error("second half missing");
endmodule
`default_nettype wire

// ----- tb/sv/tb_md4_message_digest_core.sv -----
// testbench for the md4 message digest core: random and directed messages
`timescale 1ns / 100ps
`default_nettype none
module tb_md4_message_digest_core;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  md4_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  md4_pkg::out_req_t out_data;

  // idle odds in percent for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // predicted digest halves, oldest first
  md4_pkg::out_req_t digest_queue[$];

  // predictor copy of the hash state
  logic [31:0] chain_q[4];
  logic [31:0] block_q[16];
  logic [5:0]  pos_q;
  logic [63:0] bitlen_q;

  always #5 clk = ~clk;

  md4_message_digest_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // message schedule and rotation per round, written out independently
  function automatic int msg_index(input int r);
    int i;
    i = r % 16;
    if (r < 16) return i;
    if (r < 32) return (i % 4) * 4 + i / 4;
    return ((i & 1) << 3) | ((i & 2) << 1) | ((i & 4) >> 1) | ((i & 8) >> 3);
  endfunction

  function automatic int rot_by(input int r);
    int s1[4];
    int s2[4];
    int s3[4];
    s1 = '{3, 7, 11, 19};
    s2 = '{3, 5, 9, 13};
    s3 = '{3, 9, 11, 15};
    if (r < 16) return s1[r % 4];
    if (r < 32) return s2[r % 4];
    return s3[r % 4];
  endfunction

  task automatic md4_compress();
    logic [31:0] v[4];
    logic [31:0] b, c, d, f, k, t;
    int slot;
    int s;
    for (int i = 0; i < 4; i++) v[i] = chain_q[i];
    for (int r = 0; r < 48; r++) begin
      slot = (4 - (r % 4)) % 4;
      b = v[(slot + 1) % 4];
      c = v[(slot + 2) % 4];
      d = v[(slot + 3) % 4];
      if (r < 16) begin
        f = (b & c) | (~b & d);
        k = 32'h0;
      end else if (r < 32) begin
        f = (b & c) | (b & d) | (c & d);
        k = md4_pkg::K1;
      end else begin
        f = b ^ c ^ d;
        k = md4_pkg::K2;
      end
      t = v[slot] + f + block_q[msg_index(r)] + k;
      s = rot_by(r);
      v[slot] = (t << s) | (t >> (32 - s));
    end
    for (int i = 0; i < 4; i++) chain_q[i] = chain_q[i] + v[i];
  endtask

  task automatic md4_restart();
    chain_q[0] = md4_pkg::INIT_A;
    chain_q[1] = md4_pkg::INIT_B;
    chain_q[2] = md4_pkg::INIT_C;
    chain_q[3] = md4_pkg::INIT_D;
    for (int i = 0; i < 16; i++) block_q[i] = '0;
    pos_q = '0;
    bitlen_q = '0;
  endtask

  task automatic store_byte(input int p, input logic [7:0] v);
    block_q[p / 4][(p % 4) * 8 +: 8] = v;
  endtask

  // advance the predictor by one request, queue digest halves on end
  task automatic md4_absorb(input md4_pkg::in_req_t req);
    int n;
    md4_pkg::out_req_t h;
    n = (req.byte_count > 3'd4) ? 4 : int'(req.byte_count);
    bitlen_q = bitlen_q + 64'(n * 8);
    for (int i = 0; i < n; i++) begin
      store_byte(pos_q, req.data_word[i * 8 +: 8]);
      pos_q = pos_q + 6'd1;
      if (pos_q == 6'd0) md4_compress();
    end
    if (req.end_of_message) begin
      store_byte(pos_q, md4_pkg::PAD_BYTE);
      for (int i = int'(pos_q) + 1; i < 64; i++) store_byte(i, 8'h00);
      if (pos_q >= 6'd56) begin
        md4_compress();
        for (int i = 0; i < 16; i++) block_q[i] = '0;
      end
      block_q[14] = bitlen_q[31:0];
      block_q[15] = bitlen_q[63:32];
      md4_compress();
      h.digest_half = {chain_q[1], chain_q[0]};
      h.half_index = 1'b0;
      h.last_half = 1'b0;
      digest_queue.push_back(h);
      h.digest_half = {chain_q[3], chain_q[2]};
      h.half_index = 1'b1;
      h.last_half = 1'b1;
      digest_queue.push_back(h);
      md4_restart();
    end
  endtask

  // drive one request, holding it until accepted at a rising edge
  task automatic send_request(input logic [31:0] word, input logic [2:0] cnt,
                              input logic eom);
    md4_pkg::in_req_t req;
    req.data_word = word;
    req.byte_count = cnt;
    req.end_of_message = eom;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    md4_absorb(req);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (digest_queue.size() != 0) @(negedge clk);
  endtask

  // message of random length, mostly full words, random byte count on the end item
  task automatic send_message(input int nwords);
    for (int i = 0; i < nwords; i++) begin
      if ($urandom_range(15) == 0)
        send_request($urandom, 3'($urandom_range(7)), 1'b0);
      else
        send_request($urandom, 3'd4, 1'b0);
    end
    send_request($urandom, 3'($urandom_range(7)), 1'b1);
  endtask

  task automatic test_directed();
    // empty message
    send_request(32'h0, 3'd0, 1'b1);
    // "abc" in one short end item
    send_request(32'h00636261, 3'd3, 1'b1);
    // extreme field values, oversize byte counts
    send_request(32'hffffffff, 3'd7, 1'b0);
    send_request(32'h00000000, 3'd5, 1'b1);
    // short item without end flag mid-message
    send_request(32'h12345678, 3'd1, 1'b0);
    send_request(32'hdeadbeef, 3'd2, 1'b0);
    send_request(32'hcafef00d, 3'd4, 1'b1);
    // 56 bytes: pad spills into a second final block
    for (int i = 0; i < 14; i++) send_request(32'ha5a5a5a5 ^ i, 3'd4, 1'b0);
    send_request(32'h0, 3'd0, 1'b1);
    // exactly 64 bytes, end item carries no bytes
    for (int i = 0; i < 16; i++) send_request($urandom, 3'd4, 1'b0);
    send_request(32'h0, 3'd0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(input int sidle, input int ridle, input int items);
    int sent;
    int n;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < items) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(18);
      send_message(n);
      sent += n + 1;
      // hold off until all digests are back now and then
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  // receiver stall generator
  always @(negedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    md4_pkg::out_req_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        $error("unexpected digest half %h", out_data.digest_half);
        fail_count++;
      end else begin
        want = digest_queue.pop_front();
        if (out_data.digest_half !== want.digest_half) begin
          $error("digest_half expected %h actual %h", want.digest_half,
                 out_data.digest_half);
          fail_count++;
        end
        if (out_data.half_index !== want.half_index) begin
          $error("half_index expected %b actual %b", want.half_index,
                 out_data.half_index);
          fail_count++;
        end
        if (out_data.last_half !== want.last_half) begin
          $error("last_half expected %b actual %b", want.last_half,
                 out_data.last_half);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    md4_restart();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(25, 54, 240);
    test_random(54, 25, 240);
    test_random(0, 0, 240);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && digest_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      if (digest_queue.size() != 0) $error("%0d digest halves missing",
                                           digest_queue.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
